/* hdl/reflow_profile_controller_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the reflow profile controller checkers
// ---------------------------------------------------------------------------
`ifndef REFLOW_PROFILE_CONTROLLER_DEFINES_SVH
`define REFLOW_PROFILE_CONTROLLER_DEFINES_SVH

// same-cycle implication, idle during reset
`define RPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rpc_pkg.sv */
// ---------------------------------------------------------------------------
// rpc_pkg
// Phase and command codes, register indexes and result layout for the
// reflow profile controller.
// ---------------------------------------------------------------------------
package rpc_pkg;

   typedef enum logic [2:0] {
      PH_WAIT      = 3'd0,
      PH_RAMP_SOAK = 3'd1,
      PH_SOAK      = 3'd2,
      PH_RAMP_PEAK = 3'd3,
      PH_REFLOW    = 3'd4,
      PH_COOL      = 3'd5,
      PH_DONE      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   localparam int CMD_BITS   = 2;
   localparam int INDEX_BITS = 3;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_SOAK_LOW    = 3'd0,
      REG_SOAK_HIGH   = 3'd1,
      REG_PEAK_LOW    = 3'd2,
      REG_PEAK_HIGH   = 3'd3,
      REG_SOAK_SECS   = 3'd4,
      REG_REFLOW_SECS = 3'd5,
      REG_COOL_DONE   = 3'd6
   } reg_index_type;

   localparam int RST_SOAK_LOW    = 150;
   localparam int RST_SOAK_HIGH   = 157;
   localparam int RST_PEAK_LOW    = 217;
   localparam int RST_PEAK_HIGH   = 227;
   localparam int RST_SOAK_SECS   = 120;
   localparam int RST_REFLOW_SECS = 60;
   localparam int RST_COOL_DONE   = 50;

   // result tdata: heater_on [0], phase [3:1], phase_changed [4], zero pad
   localparam int RSP_DATA_BITS = 8;

   typedef struct packed {
      logic      heater_on;
      phase_type phase;
      logic      phase_changed;
   } result_type;

endpackage

/* hdl/rpc_csr_regs.sv */
// ---------------------------------------------------------------------------
// rpc_csr_regs
// Profile limit and timer length registers, written through the csr channel.
// ---------------------------------------------------------------------------
module rpc_csr_regs #(
   parameter int TEMP_BITS  = 10,
   parameter int TIMER_BITS = 16,
   parameter int CSR_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [rpc_pkg::INDEX_BITS-1:0]   wr_index,
   input  logic [CSR_BITS-1:0]              wr_data,
   output logic [TEMP_BITS-1:0]             soak_low,
   output logic [TEMP_BITS-1:0]             soak_high,
   output logic [TEMP_BITS-1:0]             peak_low,
   output logic [TEMP_BITS-1:0]             peak_high,
   output logic [TIMER_BITS-1:0]            soak_secs,
   output logic [TIMER_BITS-1:0]            reflow_secs,
   output logic [TEMP_BITS-1:0]             cool_done
);

   logic [TEMP_BITS-1:0]  soak_low_ff, soak_high_ff, peak_low_ff, peak_high_ff, cool_done_ff;
   logic [TIMER_BITS-1:0] soak_secs_ff, reflow_secs_ff;
   logic [TEMP_BITS-1:0]  temp_in;
   logic [TIMER_BITS-1:0] secs_in;

   assign temp_in = wr_data[TEMP_BITS-1:0];
   assign secs_in = wr_data[TIMER_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         soak_low_ff    <= TEMP_BITS'(rpc_pkg::RST_SOAK_LOW);
         soak_high_ff   <= TEMP_BITS'(rpc_pkg::RST_SOAK_HIGH);
         peak_low_ff    <= TEMP_BITS'(rpc_pkg::RST_PEAK_LOW);
         peak_high_ff   <= TEMP_BITS'(rpc_pkg::RST_PEAK_HIGH);
         soak_secs_ff   <= TIMER_BITS'(rpc_pkg::RST_SOAK_SECS);
         reflow_secs_ff <= TIMER_BITS'(rpc_pkg::RST_REFLOW_SECS);
         cool_done_ff   <= TEMP_BITS'(rpc_pkg::RST_COOL_DONE);
      end else if (wr_en) begin
         case (rpc_pkg::reg_index_type'(wr_index))
            rpc_pkg::REG_SOAK_LOW:    soak_low_ff    <= temp_in;
            rpc_pkg::REG_SOAK_HIGH:   soak_high_ff   <= temp_in;
            rpc_pkg::REG_PEAK_LOW:    peak_low_ff    <= temp_in;
            rpc_pkg::REG_PEAK_HIGH:   peak_high_ff   <= temp_in;
            rpc_pkg::REG_SOAK_SECS:   soak_secs_ff   <= secs_in;
            rpc_pkg::REG_REFLOW_SECS: reflow_secs_ff <= secs_in;
            rpc_pkg::REG_COOL_DONE:   cool_done_ff   <= temp_in;
            default: ;
         endcase
      end
   end

   assign soak_low    = soak_low_ff;
   assign soak_high   = soak_high_ff;
   assign peak_low    = peak_low_ff;
   assign peak_high   = peak_high_ff;
   assign soak_secs   = soak_secs_ff;
   assign reflow_secs = reflow_secs_ff;
   assign cool_done   = cool_done_ff;

endmodule

/* hdl/rpc_sequencer.sv */
// ---------------------------------------------------------------------------
// rpc_sequencer
// Phase state machine, heater relay and one-shot seconds timer. Commits one
// request per strobe and presents the result it produces.
// ---------------------------------------------------------------------------
module rpc_sequencer #(
   parameter int TEMP_BITS  = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        commit,
   input  logic [rpc_pkg::CMD_BITS-1:0] cmd,
   input  logic [TEMP_BITS-1:0]        temp,
   input  logic [TEMP_BITS-1:0]        soak_low,
   input  logic [TEMP_BITS-1:0]        soak_high,
   input  logic [TEMP_BITS-1:0]        peak_low,
   input  logic [TEMP_BITS-1:0]        peak_high,
   input  logic [TIMER_BITS-1:0]       soak_secs,
   input  logic [TIMER_BITS-1:0]       reflow_secs,
   input  logic [TEMP_BITS-1:0]        cool_done,
   output rpc_pkg::result_type         result
);

   rpc_pkg::phase_type    phase_ff, phase_in;
   logic                  relay_ff, relay_in;
   logic [TIMER_BITS-1:0] secs_ff, secs_in;
   logic                  expired_ff, expired_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rpc_pkg::PH_WAIT;
         relay_ff   <= 1'b0;
         secs_ff    <= '0;
         expired_ff <= 1'b0;
      end else if (commit) begin
         phase_ff   <= phase_in;
         relay_ff   <= relay_in;
         secs_ff    <= secs_in;
         expired_ff <= expired_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      relay_in   = relay_ff;
      secs_in    = secs_ff;
      expired_in = expired_ff;
      case (rpc_pkg::cmd_type'(cmd))
         rpc_pkg::CMD_START: begin
            if (phase_ff == rpc_pkg::PH_WAIT) begin
               phase_in = rpc_pkg::PH_RAMP_SOAK;
               relay_in = 1'b1;
            end
         end
         rpc_pkg::CMD_TICK: begin
            if (secs_ff != '0) begin
               secs_in = secs_ff - TIMER_BITS'(1);
               if (secs_ff == TIMER_BITS'(1)) begin
                  expired_in = 1'b1;
               end
            end
         end
         rpc_pkg::CMD_SAMPLE: begin
            case (phase_ff)
               rpc_pkg::PH_RAMP_SOAK: begin
                  if (temp > soak_low) begin
                     phase_in   = rpc_pkg::PH_SOAK;
                     secs_in    = soak_secs;
                     expired_in = (soak_secs == '0);
                  end
               end
               rpc_pkg::PH_SOAK: begin
                  // low limit applied last so it wins when limits cross
                  if (temp > soak_high) relay_in = 1'b0;
                  if (temp < soak_low) relay_in = 1'b1;
                  if (expired_ff) begin
                     expired_in = 1'b0;
                     phase_in   = rpc_pkg::PH_RAMP_PEAK;
                     relay_in   = 1'b1;
                  end
               end
               rpc_pkg::PH_RAMP_PEAK: begin
                  if (temp >= peak_low) begin
                     phase_in   = rpc_pkg::PH_REFLOW;
                     secs_in    = reflow_secs;
                     expired_in = (reflow_secs == '0);
                  end
               end
               rpc_pkg::PH_REFLOW: begin
                  if (temp > peak_high) relay_in = 1'b0;
                  if (temp < peak_low) relay_in = 1'b1;
                  if (expired_ff) begin
                     expired_in = 1'b0;
                     phase_in   = rpc_pkg::PH_COOL;
                     relay_in   = 1'b0;
                  end
               end
               rpc_pkg::PH_COOL: begin
                  if (temp < cool_done) phase_in = rpc_pkg::PH_DONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign result.heater_on     = relay_in;
   assign result.phase         = phase_in;
   assign result.phase_changed = (phase_in != phase_ff);

endmodule

/* hdl/reflow_profile_controller.sv */
// ---------------------------------------------------------------------------
// reflow_profile_controller
// Solder reflow profile sequencer driving one heater relay.
//
//   channel | direction | payload
//   req_    | in        | tuser: command [1:0]; tdata: sample_temp, zero pad
//   rsp_    | out       | tdata: heater_on, phase, phase_changed, zero pad
//   csr_    | in        | csr_index: register, csr_data: value
//
// One request per cycle sustained while results are taken. An accepted request
// waits in the input register until the result register is free; the phase
// logic then loads the result register. Reset clears the phase, relay,
// timer and all valid flags; registers return to their default profile.
// A stalled result holds; the input register takes one more request, then
// back-pressure reaches req_tready.
// ---------------------------------------------------------------------------
module reflow_profile_controller #(
   parameter int TEMP_BITS  = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rpc_pkg::CMD_BITS-1:0]          req_tuser,  // command
   input  logic [((TEMP_BITS+7)/8)*8-1:0]        req_tdata,  // sample_temp, pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // heater_on [0], phase [3:1], phase_changed [4], pad
   output logic [rpc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rpc_pkg::INDEX_BITS-1:0]        csr_index,
   input  logic [((TEMP_BITS > TIMER_BITS) ? TEMP_BITS : TIMER_BITS)-1:0] csr_data
);

   localparam int CSR_BITS = (TEMP_BITS > TIMER_BITS) ? TEMP_BITS : TIMER_BITS;

   logic                         in_valid_ff;
   logic [rpc_pkg::CMD_BITS-1:0] in_cmd_ff;
   logic [TEMP_BITS-1:0]         in_temp_ff;
   logic                         out_valid_ff;
   rpc_pkg::result_type          out_result_ff;
   logic                         advance;
   rpc_pkg::result_type          result;

   logic [TEMP_BITS-1:0]  soak_low, soak_high, peak_low, peak_high, cool_done;
   logic [TIMER_BITS-1:0] soak_secs, reflow_secs;

   // move the held request into the result register when that slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_temp_ff <= req_tdata[TEMP_BITS-1:0];
      end
      if (advance) out_result_ff <= result;
   end

   rpc_csr_regs #(
      .TEMP_BITS  (TEMP_BITS),
      .TIMER_BITS (TIMER_BITS),
      .CSR_BITS   (CSR_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_valid && csr_ready),
      .wr_index    (csr_index),
      .wr_data     (csr_data),
      .soak_low    (soak_low),
      .soak_high   (soak_high),
      .peak_low    (peak_low),
      .peak_high   (peak_high),
      .soak_secs   (soak_secs),
      .reflow_secs (reflow_secs),
      .cool_done   (cool_done)
   );

   rpc_sequencer #(
      .TEMP_BITS  (TEMP_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .cmd         (in_cmd_ff),
      .temp        (in_temp_ff),
      .soak_low    (soak_low),
      .soak_high   (soak_high),
      .peak_low    (peak_low),
      .peak_high   (peak_high),
      .soak_secs   (soak_secs),
      .reflow_secs (reflow_secs),
      .cool_done   (cool_done),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff.phase_changed, out_result_ff.phase,
                        out_result_ff.heater_on};

endmodule

/* hdl/rpc_checker.sv */
// ---------------------------------------------------------------------------
// rpc_checker
// Port-level checks on the reflow profile controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "reflow_profile_controller_defines.svh"

module rpc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [rpc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata
);

   `RPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   `RPC_ASSERT_NOW(a_wait_quiet, clock, reset,
      rsp_tvalid && rsp_tdata[3:1] == rpc_pkg::PH_WAIT,
      !rsp_tdata[0] && !rsp_tdata[4], "heater or phase change while waiting")

   `RPC_ASSERT_NOW(a_ramp_heats, clock, reset,
      rsp_tvalid && rsp_tdata[4] && (rsp_tdata[3:1] == rpc_pkg::PH_RAMP_SOAK ||
      rsp_tdata[3:1] == rpc_pkg::PH_RAMP_PEAK),
      rsp_tdata[0], "heater off on entry to a ramp")

   `RPC_ASSERT_NOW(a_cool_off, clock, reset,
      rsp_tvalid && rsp_tdata[4] && rsp_tdata[3:1] == rpc_pkg::PH_COOL,
      !rsp_tdata[0], "heater on at entry to cooling")

endmodule

bind reflow_profile_controller rpc_checker u_rpc_checker (.*);

/* tb/sv/reflow_result_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reflow_result_checker
// Watches the request, result and register channels of the reflow profile
// controller, tracks the profile phase, relay and seconds timer on its own,
// and compares every result against the status predicted for the oldest
// outstanding request.
// ---------------------------------------------------------------------------
module reflow_result_checker import rpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [CMD_BITS-1:0]      req_tuser,   // command
   input  logic [15:0]              req_tdata,   // sample_temp [9:0], zero pad
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // heater_on [0], phase [3:1], phase_changed [4], zero pad
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [INDEX_BITS-1:0]    csr_index,
   input  logic [15:0]              csr_data,
   output int                       fail_count,
   output int                       pending,
   output int                       results_seen,
   output int                       phase_steps,
   output phase_type                profile_phase
);

   typedef struct {
      logic      heater;
      phase_type phase;
      logic      changed;
   } oven_status_type;

   oven_status_type status_queue[$];

   // profile state
   phase_type   ph;
   logic        relay;
   logic [15:0] secs_left;
   logic        expired;

   // register copies
   logic [9:0]  soak_lo, soak_hi, peak_lo, peak_hi, cool_lim;
   logic [15:0] soak_len, reflow_len;

   task automatic load_timer(input logic [15:0] len);
      secs_left = len;
      expired   = (len == 16'd0);
   endtask

   // relay-on is applied last, so it wins when the limits cross
   task automatic hold_band(input logic [9:0] t, input logic [9:0] lo, input logic [9:0] hi);
      if (t > hi)
         relay = 1'b0;
      if (t < lo)
         relay = 1'b1;
   endtask

   task automatic step_profile(input logic [CMD_BITS-1:0] cmd, input logic [9:0] t,
                               output oven_status_type st);
      phase_type prev;
      prev = ph;
      case (cmd)
         CMD_START: begin
            if (ph == PH_WAIT) begin
               ph    = PH_RAMP_SOAK;
               relay = 1'b1;
            end
         end
         CMD_TICK: begin
            if (secs_left != 16'd0) begin
               secs_left = secs_left - 16'd1;
               if (secs_left == 16'd0)
                  expired = 1'b1;
            end
         end
         CMD_SAMPLE: begin
            case (ph)
               PH_RAMP_SOAK: begin
                  if (t > soak_lo) begin
                     ph = PH_SOAK;
                     load_timer(soak_len);
                  end
               end
               PH_SOAK: begin
                  hold_band(t, soak_lo, soak_hi);
                  if (expired) begin
                     expired = 1'b0;
                     ph      = PH_RAMP_PEAK;
                     relay   = 1'b1;
                  end
               end
               PH_RAMP_PEAK: begin
                  if (t >= peak_lo) begin
                     ph = PH_REFLOW;
                     load_timer(reflow_len);
                  end
               end
               PH_REFLOW: begin
                  hold_band(t, peak_lo, peak_hi);
                  if (expired) begin
                     expired = 1'b0;
                     ph      = PH_COOL;
                     relay   = 1'b0;
                  end
               end
               PH_COOL: begin
                  if (t < cool_lim)
                     ph = PH_DONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      st.heater  = relay;
      st.phase   = ph;
      st.changed = (ph != prev);
   endtask

   always @(posedge clock) begin : watch
      oven_status_type want;
      if (reset) begin
         ph         = PH_WAIT;
         relay      = 1'b0;
         secs_left  = 16'd0;
         expired    = 1'b0;
         soak_lo    = 10'(RST_SOAK_LOW);
         soak_hi    = 10'(RST_SOAK_HIGH);
         peak_lo    = 10'(RST_PEAK_LOW);
         peak_hi    = 10'(RST_PEAK_HIGH);
         cool_lim   = 10'(RST_COOL_DONE);
         soak_len   = 16'(RST_SOAK_SECS);
         reflow_len = 16'(RST_REFLOW_SECS);
         status_queue.delete();
         fail_count    <= 0;
         pending       <= 0;
         results_seen  <= 0;
         phase_steps   <= 0;
         profile_phase <= PH_WAIT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SOAK_LOW:    soak_lo    = csr_data[9:0];
               REG_SOAK_HIGH:   soak_hi    = csr_data[9:0];
               REG_PEAK_LOW:    peak_lo    = csr_data[9:0];
               REG_PEAK_HIGH:   peak_hi    = csr_data[9:0];
               REG_SOAK_SECS:   soak_len   = csr_data;
               REG_REFLOW_SECS: reflow_len = csr_data;
               REG_COOL_DONE:   cool_lim   = csr_data[9:0];
               default: ;
            endcase
         end
         // retire before predicting: a result can never belong to this cycle's request
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (status_queue.size() == 0) begin
               $display("%0t ns: result with no request outstanding: heater_on=%0d phase=%0d",
                        $time, rsp_tdata[0], rsp_tdata[3:1], " phase_changed=%0d",
                        rsp_tdata[4]);
               fail_count <= fail_count + 1;
            end else begin
               want = status_queue.pop_front();
               if (rsp_tdata[0] !== want.heater || rsp_tdata[3:1] !== want.phase ||
                   rsp_tdata[4] !== want.changed) begin
                  $display("%0t ns: expected heater_on=%0d phase=%0d phase_changed=%0d",
                           $time, want.heater, want.phase, want.changed,
                           ", actual heater_on=%0d phase=%0d phase_changed=%0d",
                           rsp_tdata[0], rsp_tdata[3:1], rsp_tdata[4]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_profile(req_tuser, req_tdata[9:0], want);
            status_queue.push_back(want);
            if (want.changed)
               phase_steps <= phase_steps + 1;
         end
         pending       <= status_queue.size();
         profile_phase <= ph;
      end
   end

endmodule

/* tb/sv/tb_reflow_profile_controller.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_reflow_profile_controller
// Drives one reflow profile from waiting to finished: directed edge samples
// first, then random samples and ticks aimed at each phase's thresholds,
// with the limits retuned between stages and random idling on both sides.
// ---------------------------------------------------------------------------
module tb_reflow_profile_controller;
   import rpc_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int TEMP_MAX       = 1023;
   localparam int STAGE_ITEMS    = 50;
   localparam int MAX_STAGES     = 40;
   localparam int HOLD_CYCLES    = 48;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [CMD_BITS-1:0]      req_tuser;   // command
   logic [15:0]              req_tdata;   // sample_temp [9:0], zero pad
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // heater_on [0], phase [3:1], phase_changed [4], zero pad
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [INDEX_BITS-1:0]    csr_index;
   logic [15:0]              csr_data;

   int        fail_count;
   int        pending;
   int        results_seen;
   int        phase_steps;
   phase_type profile_phase;

   int   send_idle_pct    = 0;
   int   stall_pct        = 0;
   logic hold_req         = 1'b0;
   logic hold_seen        = 1'b0;
   int   hold_cnt         = 0;
   int   quiet_cycles     = 0;
   int   requests_sent    = 0;
   int   settings_applied = 0;

   // limits currently programmed, used to aim the samples
   int   soak_lo  = RST_SOAK_LOW;
   int   soak_hi  = RST_SOAK_HIGH;
   int   peak_lo  = RST_PEAK_LOW;
   int   peak_hi  = RST_PEAK_HIGH;
   int   cool_lim = RST_COOL_DONE;
   int   long_len;
   logic zero_soak;

   reflow_profile_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   reflow_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .results_seen  (results_seen),
      .phase_steps   (phase_steps),
      .profile_phase (profile_phase)
   );

   always #2 clock = ~clock;

   // result side: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_seen  <= 1'b1;
         hold_cnt   <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int around(input int level);
      int v;
      if ($urandom_range(0, 99) < 15)
         return $urandom_range(0, TEMP_MAX);
      v = level + int'($urandom_range(0, 6)) - 3;
      if (v < 0)
         v = 0;
      if (v > TEMP_MAX)
         v = TEMP_MAX;
      return v;
   endfunction

   task automatic send_req(input logic [CMD_BITS-1:0] cmd, input int temp);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= 16'(temp);
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic write_reg(input reg_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   // hold requests until every outstanding result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic pick_band(input int k, output int lo, output int hi);
      lo = $urandom_range(120, 260);
      case (k % 4)
         0: hi = lo + int'($urandom_range(0, 12));
         1: hi = lo - int'($urandom_range(1, 15));
         2: begin
            lo = (k % 8 == 2) ? 0 : TEMP_MAX;
            hi = TEMP_MAX - lo;
         end
         default: hi = lo;
      endcase
   endtask

   task automatic retune(input int k);
      pick_band(k, soak_lo, soak_hi);
      pick_band(k, peak_lo, peak_hi);
      if (k % 4 != 2)
         cool_lim = $urandom_range(30, 400);
      else
         cool_lim = (k % 8 == 2) ? 0 : TEMP_MAX;
      write_reg(REG_SOAK_LOW, soak_lo);
      write_reg(REG_SOAK_HIGH, soak_hi);
      write_reg(REG_PEAK_LOW, peak_lo);
      write_reg(REG_PEAK_HIGH, peak_hi);
      write_reg(REG_COOL_DONE, cool_lim);
      // both timers are loaded by now, so their lengths can go to the extremes
      if (profile_phase >= PH_REFLOW) begin
         write_reg(REG_SOAK_SECS, (k % 2 != 0) ? 65535 : 1);
         write_reg(REG_REFLOW_SECS, (k % 2 != 0) ? 1 : 65535);
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic pick_item(output logic [CMD_BITS-1:0] cmd, output int temp);
      int r;
      r    = $urandom_range(0, 99);
      cmd  = CMD_SAMPLE;
      temp = $urandom_range(0, TEMP_MAX);
      if (r < 5)
         cmd = CMD_BITS'($urandom_range(0, 3));
      else if (r < 30)
         cmd = CMD_TICK;
      else begin
         case (profile_phase)
            PH_RAMP_SOAK: temp = around(soak_lo);
            PH_SOAK:      temp = around($urandom_range(0, 1) ? soak_lo : soak_hi);
            PH_RAMP_PEAK: temp = around(peak_lo);
            PH_REFLOW:    temp = around($urandom_range(0, 1) ? peak_lo : peak_hi);
            PH_COOL: begin
               // keep cooling going for a while: mostly samples at or above the limit
               if ($urandom_range(0, 99) >= 3)
                  temp = $urandom_range(cool_lim, TEMP_MAX);
            end
            default: cmd = CMD_BITS'($urandom_range(0, 3));
         endcase
      end
   endtask

   initial begin
      int                  k;
      int                  done_stages;
      int                  temp;
      logic [CMD_BITS-1:0] cmd;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // waiting: samples, ticks and the unused code change nothing
      send_req(CMD_SAMPLE, 0);
      send_req(CMD_SAMPLE, TEMP_MAX);
      send_req(CMD_TICK, 0);
      send_req(CMD_UNUSED, TEMP_MAX);
      send_req(CMD_START, 0);
      // ramp to soak: a repeated start is ignored, equal to the limit stays
      send_req(CMD_START, TEMP_MAX);
      send_req(CMD_SAMPLE, 0);
      send_req(CMD_SAMPLE, RST_SOAK_LOW);
      send_req(CMD_TICK, TEMP_MAX);
      send_req(CMD_UNUSED, 0);

      // one timer gets zero length and expires at load, the other runs long
      drain();
      zero_soak = $urandom_range(0, 1);
      long_len  = $urandom_range(160, 220);
      write_reg(REG_SOAK_LOW, soak_lo);
      write_reg(REG_SOAK_HIGH, soak_hi);
      write_reg(REG_PEAK_LOW, peak_lo);
      write_reg(REG_PEAK_HIGH, peak_hi);
      write_reg(REG_SOAK_SECS, zero_soak ? 0 : long_len);
      write_reg(REG_REFLOW_SECS, zero_soak ? long_len : 0);
      write_reg(REG_COOL_DONE, cool_lim);
      csr_valid <= 1'b0;
      settings_applied++;

      send_req(CMD_SAMPLE, soak_lo + 1);
      send_req(CMD_SAMPLE, soak_hi + 1);
      send_req(CMD_SAMPLE, soak_hi);
      send_req(CMD_SAMPLE, soak_lo);
      send_req(CMD_SAMPLE, soak_lo - 1);
      send_req(CMD_SAMPLE, TEMP_MAX);
      send_req(CMD_TICK, 0);
      send_req(CMD_SAMPLE, 0);

      done_stages = 0;
      for (k = 0; k < MAX_STAGES && done_stages < 1; k++) begin
         drain();
         if (profile_phase == PH_DONE)
            done_stages++;
         retune(k);
         case (k % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 67;
            end
            default: begin
               send_idle_pct = 16;
               stall_pct <= 16;
            end
         endcase
         // long receiver hold-off while requests keep coming
         if (k == 4)
            hold_req <= 1'b1;
         repeat (STAGE_ITEMS) begin
            pick_item(cmd, temp);
            send_req(cmd, temp);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d requests over %0d register settings; checked %0d results, %0d phase changes.",
               requests_sent, settings_applied, results_seen, phase_steps);
      $display("Profile ended in %s with the zero-length timer on %s and a %0d-tick timer.",
               profile_phase.name(), zero_soak ? "soak" : "reflow", long_len);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* reflow_profile_controller.f */
+incdir+hdl
hdl/rpc_pkg.sv
hdl/rpc_csr_regs.sv
hdl/rpc_sequencer.sv
hdl/reflow_profile_controller.sv
hdl/rpc_checker.sv
tb/sv/reflow_result_checker.sv
tb/sv/tb_reflow_profile_controller.sv
